// ===== hdl/fcs_pkg.sv =====
// Package for the mod-255 Fletcher checksum block.
// Holds the item carried from the front end to the back end and shared constants.
// No dependencies.
package fcs_pkg;

    localparam logic [7:0] MOD_BASE = 8'd255;
    localparam int OFFSET_W = 12;

    // One classified octet as it travels through the queue.
    typedef struct packed {
        logic [7:0] octet;      // octet after checksum-field zeroing
        logic       last;       // final octet of the packet
        logic       gen;        // generate mode on this octet
        logic [7:0] len_diff;   // (len - offset - 1) mod 255, valid on last
        logic       overlong;   // packet ran past the length limit
    } fcs_item_t;

endpackage

// ===== hdl/iso_fletcher_checksum.sv =====
// Top level of the mod-255 Fletcher checksum (check and generate modes).
// Instantiates fcs_front, fcs_fifo and fcs_back; uses fcs_pkg.
//
//  Channel   Direction  Contents
//  s_*       in         one packet octet per transaction, tlast on the final octet
//  m_*       out        one result per packet
//
// Octets are taken one per cycle while the queue is not full; after the last octet is
// accepted, the result passes the queue, sum stage and multiplier stage and then waits in
// the output register until m_tready is high.
// rst_n clears counters, sums, the queue and all valid flags asynchronously.
// A stalled output halts the back end; the queue then absorbs up to
// QUEUE_DEPTH octets before s_tready drops.
module iso_fletcher_checksum
    import fcs_pkg::*;
#(
    parameter int MAX_LEN     = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], csum_offset[19:8], zero pad
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // check_residue[15:0], check_error[16], x_byte[24:17],
                                   // y_byte[32:25], too_long[33], zero pad
);

    logic      push, pop, full, empty;
    fcs_item_t front_item, queue_item;

    fcs_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .push     (push),
        .item     (front_item),
        .full     (full)
    );

    fcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_item),
        .full  (full),
        .pop   (pop),
        .dout  (queue_item),
        .empty (empty)
    );

    fcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (queue_item),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/fcs_fifo.sv =====
// Small register queue between the front end and the back end.
// Depends on fcs_pkg for the item type.
module fcs_fifo
    import fcs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  fcs_item_t din,
    output logic      full,
    input  logic      pop,
    output fcs_item_t dout,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fcs_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hdl/fcs_front.sv =====
// Front end: counts octets, zeroes the checksum field in generate mode and
// works out the length term of the generate formula. Depends on fcs_pkg.
module fcs_front
    import fcs_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // data_byte[7:0], csum_offset[19:8], zero pad
    input  logic                s_tlast,
    input  logic                s_tuser,   // req_type
    output logic                push,
    output fcs_item_t           item,
    input  logic                full
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W = (POS_W > OFFSET_W + 1) ? POS_W : OFFSET_W + 1;

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]             mod_reg, mod_next;
    logic                   ovl_reg, ovl_next;

    logic [7:0]             octet_in;
    logic [OFFSET_W-1:0]    offset;
    logic [CMP_W-1:0]       pos_ext, off_ext;
    logic                   in_field;
    logic                   saturated;
    logic [OFFSET_W:0]      off1;
    logic [8:0]             fold_sum;
    logic [7:0]             b_mod;
    logic [7:0]             a_mod;

    assign octet_in  = s_tdata[7:0];
    assign offset    = s_tdata[19:8];
    assign s_tready  = !full;
    assign push      = s_tvalid && !full;

    assign pos_ext   = CMP_W'(pos_reg);
    assign off_ext   = CMP_W'(offset);
    assign in_field  = s_tuser && !ovl_reg &&
                       ((pos_ext == off_ext) || (pos_ext == off_ext + CMP_W'(1)));
    assign saturated = (pos_reg >= POS_W'(MAX_LEN));

    // Offset plus one reduced mod 255: 256 is congruent to 1, so fold the high bits.
    assign off1      = {1'b0, offset} + (OFFSET_W + 1)'(1);
    assign fold_sum  = 9'(off1[OFFSET_W:8]) + {1'b0, off1[7:0]};
    assign b_mod     = (fold_sum >= 9'(MOD_BASE)) ? 8'(fold_sum - 9'(MOD_BASE))
                                                  : fold_sum[7:0];

    always_comb
    begin
        pos_next = pos_reg;
        mod_next = mod_reg;
        ovl_next = ovl_reg;
        if (saturated)
        begin
            ovl_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
            mod_next = (mod_reg == MOD_BASE - 8'd1) ? 8'd0 : mod_reg + 8'd1;
        end
    end

    assign a_mod = mod_next;

    always_comb
    begin
        item.octet    = in_field ? 8'd0 : octet_in;
        item.last     = s_tlast;
        item.gen      = s_tuser;
        item.len_diff = (a_mod >= b_mod) ? a_mod - b_mod : a_mod + (MOD_BASE - b_mod);
        item.overlong = ovl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            mod_reg <= '0;
            ovl_reg <= 1'b0;
        end
        else if (push)
        begin
            if (s_tlast)
            begin
                pos_reg <= '0;
                mod_reg <= '0;
                ovl_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                mod_reg <= mod_next;
                ovl_reg <= ovl_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_LEN))
        else $error("octet count passed the length limit");
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_reg != MOD_BASE)
        else $error("length residue left the range 0..254");
    a_ovl_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ovl_reg |-> (pos_reg == POS_W'(MAX_LEN)))
        else $error("overlong flag set without a saturated count");
`endif

endmodule

// ===== hdl/fcs_back.sv =====
// Back end: accumulates both mod-255 sums and, on the last octet, forms the
// residue or the generated checksum pair in a short pipeline. Depends on fcs_pkg.
module fcs_back
    import fcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fcs_item_t   item,
    input  logic        empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // check_residue[15:0], check_error[16], x_byte[24:17],
                                   // y_byte[32:25], too_long[33], zero pad
);

    logic       ce;
    logic [8:0] add1, add2;
    logic [7:0] s1, s2;

    logic [7:0] sum_reg, sum_next;
    logic [7:0] sum2_reg, sum2_next;

    // Packet-end stage
    logic       b_valid_reg;
    logic [7:0] b_s1_reg, b_s2_reg, b_d_reg;
    logic       b_gen_reg, b_ovl_reg;

    // Product stage
    logic        c_valid_reg;
    logic [15:0] c_prod_reg;
    logic [7:0]  c_s1_reg, c_s2_reg;
    logic        c_gen_reg, c_ovl_reg;

    // Output register
    logic        out_valid_reg;
    logic [15:0] out_res_reg;
    logic        out_err_reg;
    logic [7:0]  out_x_reg, out_y_reg;
    logic        out_ovl_reg;

    logic [8:0]  pfold;
    logic [7:0]  pmod;
    logic [7:0]  x_val;
    logic [8:0]  t_sum;
    logic [7:0]  t_mod;
    logic [7:0]  y_val;
    logic [15:0] residue;

    assign ce  = !out_valid_reg || m_tready;
    assign pop = ce && !empty;

    assign add1 = {1'b0, sum_reg} + {1'b0, item.octet};
    assign s1   = (add1 >= 9'(MOD_BASE)) ? 8'(add1 - 9'(MOD_BASE)) : add1[7:0];
    assign add2 = {1'b0, sum2_reg} + {1'b0, s1};
    assign s2   = (add2 >= 9'(MOD_BASE)) ? 8'(add2 - 9'(MOD_BASE)) : add2[7:0];

    always_comb
    begin
        sum_next  = sum_reg;
        sum2_next = sum2_reg;
        if (pop)
        begin
            sum_next  = item.last ? 8'd0 : s1;
            sum2_next = item.last ? 8'd0 : s2;
        end
    end

    // Product reduced mod 255 by folding its high byte onto the low byte.
    assign pfold   = {1'b0, c_prod_reg[15:8]} + {1'b0, c_prod_reg[7:0]};
    assign pmod    = (pfold >= 9'(MOD_BASE)) ? 8'(pfold - 9'(MOD_BASE)) : pfold[7:0];
    assign x_val   = (pmod >= c_s2_reg) ? pmod - c_s2_reg : pmod + (MOD_BASE - c_s2_reg);
    assign t_sum   = {1'b0, x_val} + {1'b0, c_s1_reg};
    assign t_mod   = (t_sum >= 9'(MOD_BASE)) ? 8'(t_sum - 9'(MOD_BASE)) : t_sum[7:0];
    assign y_val   = (t_mod == 8'd0) ? 8'd0 : MOD_BASE - t_mod;
    assign residue = {c_s1_reg, c_s2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            sum2_reg      <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            sum2_reg <= sum2_next;
            if (ce)
            begin
                b_valid_reg   <= pop && item.last;
                c_valid_reg   <= b_valid_reg;
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            b_s1_reg  <= s1;
            b_s2_reg  <= s2;
            b_d_reg   <= item.len_diff;
            b_gen_reg <= item.gen;
            b_ovl_reg <= item.overlong;

            c_prod_reg <= 16'(b_s1_reg) * 16'(b_d_reg);
            c_s1_reg   <= b_s1_reg;
            c_s2_reg   <= b_s2_reg;
            c_gen_reg  <= b_gen_reg;
            c_ovl_reg  <= b_ovl_reg;

            out_res_reg <= c_gen_reg ? 16'd0 : residue;
            out_err_reg <= !c_gen_reg && (residue != 16'd0);
            out_x_reg   <= c_gen_reg ? x_val : 8'd0;
            out_y_reg   <= c_gen_reg ? y_val : 8'd0;
            out_ovl_reg <= c_ovl_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_ovl_reg, out_y_reg, out_x_reg, out_err_reg, out_res_reg};

`ifndef SYNTHESIS
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg != MOD_BASE) && (sum2_reg != MOD_BASE))
        else $error("running sum left the range 0..254");
    a_xy_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_x_reg != MOD_BASE) && (out_y_reg != MOD_BASE))
        else $error("generated checksum octet equals 255");
    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg != 16'd0))
            |-> (out_x_reg == 8'd0) && (out_y_reg == 8'd0))
        else $error("check and generate results both present");
    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.last) |=> (sum_reg == 8'd0) && (sum2_reg == 8'd0))
        else $error("sums not cleared after the last octet");
`endif

endmodule

// ===== tb/fcs_checker.sv =====
// Scoreboard for the mod-255 Fletcher checksum block: watches both stream channels,
// predicts one result per packet and compares it with what the block delivers.
// Depends on fcs_pkg for the modulus.
module fcs_checker
    import fcs_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], csum_offset[19:8], zero pad
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // check_residue[15:0], check_error[16], x_byte[24:17],
                                   // y_byte[32:25], too_long[33], zero pad
    output int          pending,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODULUS = int'(MOD_BASE);

    typedef struct packed {
        logic [15:0] residue;
        logic        residue_nonzero;
        logic [7:0]  x_octet;
        logic [7:0]  y_octet;
        logic        too_long;
    } fletcher_result_t;

    // Running state of the packet in progress.
    int sum_a = 0;
    int sum_b = 0;
    int octets_seen = 0;
    bit past_limit = 1'b0;

    fletcher_result_t results_due[$];
    int mismatches = 0;

    assign fail_count = mismatches;

    task automatic absorb_octet(input logic gen, input logic [7:0] data, input logic last,
                                input logic [11:0] offset);
        int octet;
        int len_mod;
        int diff;
        fletcher_result_t r;
        octet = data;
        // The two checksum octets are summed as zero while they are generated.
        if (gen && !past_limit && (octets_seen == offset || octets_seen == offset + 1))
            octet = 0;
        sum_a = (sum_a + octet) % MODULUS;
        sum_b = (sum_b + sum_a) % MODULUS;
        if (octets_seen >= MAX_LEN)
            past_limit = 1'b1;
        else
            octets_seen++;
        if (last)
        begin
            r = '0;
            if (gen)
            begin
                len_mod   = octets_seen % MODULUS;
                diff      = (len_mod + MODULUS - ((offset + 1) % MODULUS)) % MODULUS;
                r.x_octet = 8'((sum_a * diff + MODULUS - sum_b) % MODULUS);
                r.y_octet = 8'((2 * MODULUS - int'(r.x_octet) - sum_a) % MODULUS);
            end
            else
            begin
                r.residue         = {sum_a[7:0], sum_b[7:0]};
                r.residue_nonzero = (r.residue != 16'd0);
            end
            r.too_long = past_limit;
            results_due.push_back(r);
            sum_a       = 0;
            sum_b       = 0;
            octets_seen = 0;
            past_limit  = 1'b0;
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        fletcher_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                absorb_octet(s_tuser, s_tdata[7:0], s_tlast, s_tdata[19:8]);
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result transaction 0x%0h with no packet outstanding", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("check_residue", want.residue, m_tdata[15:0]);
                    compare_field("check_error", want.residue_nonzero, m_tdata[16]);
                    compare_field("x_byte", want.x_octet, m_tdata[24:17]);
                    compare_field("y_byte", want.y_octet, m_tdata[32:25]);
                    compare_field("too_long", want.too_long, m_tdata[33]);
                end
            end
        end
        pending = results_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for iso_fletcher_checksum: clock, reset, packet stimulus
// with bursty input and a stalling output, and the final verdict.
// Depends on fcs_pkg, the block itself and fcs_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fcs_pkg::*;

    localparam int MAX_LEN = 4096;
    localparam int RANDOM_OCTETS = 650;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;

    int pending;
    int fail_count;

    int burst_left = 0;
    bit sender_quiet = 1'b0;
    int rx_stall = 0;
    logic [15:0] rx_cycle = '0;

    always #2 clk = ~clk;

    iso_fletcher_checksum #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    fcs_checker #(
        .MAX_LEN(MAX_LEN)
    ) scoreboard (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .pending(pending),
        .fail_count(fail_count)
    );

    // The receiver starts a stall only while bit 8 of rx_cycle is set; a stall may run on past that window.
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else if (rx_cycle[8] && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= $urandom_range(0, 7);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] pick_octet();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_octet(input logic gen, input logic [7:0] data, input logic last,
                              input logic [11:0] offset);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_quiet ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, offset, data};
        s_tlast  <= last;
        s_tuser  <= gen;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_packet(input logic gen, input int len, input logic [11:0] offset);
        for (int i = 0; i < len; i++)
            send_octet(gen, pick_octet(), i == len - 1, offset);
    endtask

    initial
    begin
        int sent;
        int len;
        int offset;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single-octet check packets at both extremes of the octet value, then a three-octet check packet.
        send_octet(1'b0, 8'h00, 1'b1, 12'd0);
        send_octet(1'b0, 8'hFF, 1'b1, 12'hFFF);
        send_octet(1'b0, 8'h01, 1'b0, 12'd0);
        send_octet(1'b0, 8'hFF, 1'b0, 12'd0);
        send_octet(1'b0, 8'h80, 1'b1, 12'd0);
        // Generate with the checksum field at the start, then at the very end.
        send_octet(1'b1, 8'hFF, 1'b0, 12'd0);
        send_octet(1'b1, 8'hFF, 1'b0, 12'd0);
        send_octet(1'b1, 8'h12, 1'b0, 12'd0);
        send_octet(1'b1, 8'hFE, 1'b1, 12'd0);
        send_octet(1'b1, 8'h34, 1'b0, 12'd2);
        send_octet(1'b1, 8'h56, 1'b0, 12'd2);
        send_octet(1'b1, 8'hAA, 1'b0, 12'd2);
        send_octet(1'b1, 8'h55, 1'b1, 12'd2);
        // Offset beyond the packet, so the length term wraps negative.
        send_octet(1'b1, 8'hC3, 1'b0, 12'hFFF);
        send_octet(1'b1, 8'h3C, 1'b1, 12'hFFF);
        // Only the first checksum octet lies inside the packet.
        send_octet(1'b1, 8'h10, 1'b0, 12'd2);
        send_octet(1'b1, 8'h20, 1'b0, 12'd2);
        send_octet(1'b1, 8'h30, 1'b1, 12'd2);
        // Mode changes inside a packet; the last octet picks the result kind.
        send_octet(1'b1, 8'h77, 1'b0, 12'd0);
        send_octet(1'b0, 8'h88, 1'b0, 12'd0);
        send_octet(1'b0, 8'h99, 1'b1, 12'd0);
        send_octet(1'b0, 8'hEE, 1'b0, 12'd1);
        send_octet(1'b1, 8'hDD, 1'b0, 12'd1);
        send_octet(1'b1, 8'hCC, 1'b1, 12'd1);

        sent = 0;
        while (sent < RANDOM_OCTETS)
        begin
            sender_quiet = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_packet(1'b0, len, 12'($urandom_range(0, 4095)));
                else
                begin
                    offset = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, len - 1);
                    send_packet(1'b1, len, 12'(offset));
                end
            end
            else
            begin
                for (int i = 0; i < len; i++)
                begin
                    offset = $urandom_range(0, 1) ? $urandom_range(0, len)
                                                  : $urandom_range(0, 4095);
                    send_octet(1'($urandom_range(0, 1)), pick_octet(), i == len - 1,
                               12'(offset));
                end
            end
            sent += len;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
